/* hdl/bsdf_pkg.sv */
// Shared types, widths and helpers for the row-bitmap delta frame decoder.
// No dependencies; used by every module under hdl/.
package bsdf_pkg;

    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 16;
    localparam int BITMAP_W     = 32;
    localparam int SEG_W        = 6;
    localparam int ROW_W        = 8;
    localparam int BMCNT_W      = 3;
    localparam logic [BMCNT_W-1:0] BITMAP_BYTES = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [BYTE_W-1:0] pixel_value;
        logic              write_enable;
        logic              frame_done;
    } result_t;

    // Lowest segment index s with from <= s < limit whose bitmap bit (31 - s)
    // is set; returns limit when none is.
    function automatic logic [SEG_W-1:0] next_seg(
        input logic [BITMAP_W-1:0] bits,
        input logic [SEG_W-1:0]    from,
        input logic [SEG_W-1:0]    limit
    );
        logic [SEG_W-1:0] found;
        found = limit;
        for (int s = BITMAP_W - 1; s >= 0; s--)
        begin
            if ((SEG_W'(s) >= from) && (SEG_W'(s) < limit) && bits[BITMAP_W - 1 - s])
            begin
                found = SEG_W'(s);
            end
        end
        return found;
    endfunction

endpackage

/* hdl/bsdf_decode.sv */
// Decode state and per-byte update logic: raw frame counter, row bitmap,
// segment and byte counters, pixel address. Depends on bsdf_pkg.
module bsdf_decode #(
    parameter int FRAME_WIDTH      = 320,
    parameter int FRAME_HEIGHT     = 180,
    parameter int SEGMENT_BYTES    = 10,
    parameter int SEGMENTS_PER_ROW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [bsdf_pkg::BYTE_W-1:0] byte_in,
    input  logic                        restart,
    output logic                        has_result,
    output bsdf_pkg::result_t           result
);

    localparam int RAW_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int POS_W      = $clog2(RAW_PIXELS + 1);
    localparam int K_W        = $clog2(SEGMENT_BYTES + 1);
    localparam logic [bsdf_pkg::SEG_W-1:0] SEG_LIM = bsdf_pkg::SEG_W'(SEGMENTS_PER_ROW);

    logic                              raw_reg, raw_next;
    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic [bsdf_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [bsdf_pkg::ADDR_W-1:0]       row_base_reg, row_base_next;
    logic [bsdf_pkg::BITMAP_W-1:0]     bitmap_reg, bitmap_next;
    logic [bsdf_pkg::BMCNT_W-1:0]      bmcnt_reg, bmcnt_next;
    logic [bsdf_pkg::SEG_W-1:0]        seg_reg, seg_next;
    logic [K_W-1:0]                    k_reg, k_next;

    // State as seen by this byte, after an optional restart
    logic                              raw_e;
    logic [POS_W-1:0]                  pos_e;
    logic [bsdf_pkg::ROW_W-1:0]        row_e;
    logic [bsdf_pkg::ADDR_W-1:0]       row_base_e;
    logic [bsdf_pkg::BITMAP_W-1:0]     bitmap_e;
    logic [bsdf_pkg::BMCNT_W-1:0]      bmcnt_e;
    logic [bsdf_pkg::SEG_W-1:0]        seg_e;
    logic [K_W-1:0]                    k_e;

    logic [POS_W:0]                    pos_inc;
    logic [K_W:0]                      k_inc;
    logic [bsdf_pkg::ROW_W:0]          row_inc;
    logic [bsdf_pkg::SEG_W-1:0]        seg_found;
    logic [bsdf_pkg::BITMAP_W-1:0]     bitmap_shift;
    logic                              finish_row;
    logic                              last_row;

    assign raw_e      = restart ? 1'b1 : raw_reg;
    assign pos_e      = restart ? '0 : pos_reg;
    assign row_e      = restart ? '0 : row_reg;
    assign row_base_e = restart ? '0 : row_base_reg;
    assign bitmap_e   = restart ? '0 : bitmap_reg;
    assign bmcnt_e    = restart ? '0 : bmcnt_reg;
    assign seg_e      = restart ? '0 : seg_reg;
    assign k_e        = restart ? '0 : k_reg;

    assign pos_inc      = {1'b0, pos_e} + 1'b1;
    assign k_inc        = {1'b0, k_e} + 1'b1;
    assign row_inc      = {1'b0, row_e} + 1'b1;
    assign last_row     = row_inc >= (bsdf_pkg::ROW_W + 1)'(FRAME_HEIGHT);
    assign bitmap_shift = {bitmap_e[bsdf_pkg::BITMAP_W-bsdf_pkg::BYTE_W-1:0], byte_in};

    always_comb
    begin
        raw_next      = raw_e;
        pos_next      = pos_e;
        row_next      = row_e;
        row_base_next = row_base_e;
        bitmap_next   = bitmap_e;
        bmcnt_next    = bmcnt_e;
        seg_next      = seg_e;
        k_next        = k_e;
        finish_row    = 1'b0;
        seg_found     = '0;
        has_result    = 1'b0;
        result        = '0;

        if (raw_e)
        begin
            has_result           = 1'b1;
            result.pixel_address = bsdf_pkg::ADDR_W'(32'(pos_e));
            result.pixel_value   = byte_in;
            result.write_enable  = 1'b1;
            if (pos_inc >= (POS_W + 1)'(RAW_PIXELS))
            begin
                result.frame_done = 1'b1;
                pos_next          = '0;
                raw_next          = 1'b0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
        else if (bmcnt_e < bsdf_pkg::BITMAP_BYTES)
        begin
            bitmap_next = bitmap_shift;
            bmcnt_next  = bmcnt_e + 1'b1;
            if (bmcnt_next == bsdf_pkg::BITMAP_BYTES)
            begin
                seg_found = bsdf_pkg::next_seg(bitmap_shift, '0, SEG_LIM);
                seg_next  = seg_found;
                k_next    = '0;
                if (seg_found >= SEG_LIM)
                begin
                    finish_row = 1'b1;
                    // empty last row still closes the frame with a marker
                    if (last_row)
                    begin
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            has_result           = 1'b1;
            result.pixel_address = bsdf_pkg::ADDR_W'(row_base_e
                                 + bsdf_pkg::ADDR_W'(seg_e) * bsdf_pkg::ADDR_W'(SEGMENT_BYTES)
                                 + bsdf_pkg::ADDR_W'(k_e));
            result.pixel_value   = byte_in;
            result.write_enable  = 1'b1;
            if (k_inc >= (K_W + 1)'(SEGMENT_BYTES))
            begin
                k_next    = '0;
                seg_found = bsdf_pkg::next_seg(bitmap_e, seg_e + 1'b1, SEG_LIM);
                seg_next  = seg_found;
                if (seg_found >= SEG_LIM)
                begin
                    finish_row        = 1'b1;
                    result.frame_done = last_row;
                end
            end
            else
            begin
                k_next = k_inc[K_W-1:0];
            end
        end

        if (finish_row)
        begin
            bmcnt_next  = '0;
            bitmap_next = '0;
            seg_next    = '0;
            k_next      = '0;
            if (last_row)
            begin
                row_next      = '0;
                row_base_next = '0;
            end
            else
            begin
                row_next      = row_inc[bsdf_pkg::ROW_W-1:0];
                row_base_next = row_base_e + bsdf_pkg::ADDR_W'(FRAME_WIDTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg      <= 1'b1;
            pos_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            bitmap_reg   <= '0;
            bmcnt_reg    <= '0;
            seg_reg      <= '0;
            k_reg        <= '0;
        end
        else if (step)
        begin
            raw_reg      <= raw_next;
            pos_reg      <= pos_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            bitmap_reg   <= bitmap_next;
            bmcnt_reg    <= bmcnt_next;
            seg_reg      <= seg_next;
            k_reg        <= k_next;
        end
    end

endmodule

/* hdl/bsdf_out_stage.sv */
// Result register of the decoder with valid/ready toward the consumer.
// Depends on bsdf_pkg.
module bsdf_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bsdf_pkg::result_t result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output bsdf_pkg::result_t out_result
);

    logic              valid_reg, valid_next;
    bsdf_pkg::result_t result_reg;

    // free: a new result may be written this cycle
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

/* hdl/bitmap_segment_delta_frame_decoder_unit.sv */
// Row-bitmap delta frame decoder: one payload byte in, at most one pixel write out.
// Path from an accepted request to out_valid: input register, then result register.
// Throughput: one byte per cycle; the decode stage stalls only when it holds a result and
// the result register is full and not being taken.
// Reset (rst_n low, asynchronous): both registers empty, decoder back to raw first frame.
// Depends on bsdf_pkg, bsdf_decode, bsdf_out_stage.
module bitmap_segment_delta_frame_decoder_unit #(
    parameter int FRAME_WIDTH      = 320,
    parameter int FRAME_HEIGHT     = 180,
    parameter int SEGMENT_BYTES    = 10,
    parameter int SEGMENTS_PER_ROW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bsdf_pkg::BYTE_W-1:0] byte_in,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bsdf_pkg::ADDR_W-1:0] pixel_address,
    output logic [bsdf_pkg::BYTE_W-1:0] pixel_value,
    output logic                        write_enable,
    output logic                        frame_done
);

    logic                        s1_valid_reg, s1_valid_next;
    logic [bsdf_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        s1_restart_reg;
    logic                        s1_fire;
    logic                        in_fire;
    logic                        has_result;
    logic                        out_free;
    bsdf_pkg::result_t           dec_result;
    bsdf_pkg::result_t           out_result;

    // advance the held request unless its result would overwrite a full result register
    assign s1_fire       = s1_valid_reg && (!has_result || out_free);
    assign in_ready      = !s1_valid_reg || s1_fire;
    assign in_fire       = in_valid && in_ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg    <= byte_in;
            s1_restart_reg <= restart;
        end
    end

    bsdf_decode #(
        .FRAME_WIDTH      (FRAME_WIDTH),
        .FRAME_HEIGHT     (FRAME_HEIGHT),
        .SEGMENT_BYTES    (SEGMENT_BYTES),
        .SEGMENTS_PER_ROW (SEGMENTS_PER_ROW)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_fire),
        .byte_in    (s1_byte_reg),
        .restart    (s1_restart_reg),
        .has_result (has_result),
        .result     (dec_result)
    );

    bsdf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_fire && has_result),
        .result     (dec_result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign pixel_address = out_result.pixel_address;
    assign pixel_value   = out_result.pixel_value;
    assign write_enable  = out_result.write_enable;
    assign frame_done    = out_result.frame_done;

endmodule

/* bench/bitmap_segment_delta_frame_decoder_checker.sv */
`timescale 1ns / 1ps
// Checker for the row-bitmap frame decoder: follows the request channel, predicts each
// pixel write or end-of-frame marker, and compares results in order of arrival.
// Depends on bsdf_pkg for the result layout and the field widths.
module bitmap_segment_delta_frame_decoder_checker #(
    parameter int FRAME_WIDTH      = 320,
    parameter int FRAME_HEIGHT     = 180,
    parameter int SEGMENT_BYTES    = 10,
    parameter int SEGMENTS_PER_ROW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [bsdf_pkg::BYTE_W-1:0] byte_in,
    input  logic                        restart,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [bsdf_pkg::ADDR_W-1:0] pixel_address,
    input  logic [bsdf_pkg::BYTE_W-1:0] pixel_value,
    input  logic                        write_enable,
    input  logic                        frame_done,
    output int                          mismatches,
    output int                          pending
);

    localparam int unsigned SEG_LIMIT  = (SEGMENTS_PER_ROW > 32) ? 32 : SEGMENTS_PER_ROW;
    localparam int unsigned RAW_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int          AW         = bsdf_pkg::ADDR_W;
    localparam int          BW         = bsdf_pkg::BITMAP_W;

    logic              raw_mode;
    int unsigned       raw_pos;
    int unsigned       row;
    logic [BW-1:0]     bitmap;
    int unsigned       bitmap_count;
    int unsigned       seg;
    int unsigned       seg_byte;
    bsdf_pkg::result_t expected_writes[$];
    bsdf_pkg::result_t oldest;

    function automatic void restart_decoder();
        raw_mode     = 1'b1;
        raw_pos      = 0;
        row          = 0;
        bitmap       = '0;
        bitmap_count = 0;
        seg          = 0;
        seg_byte     = 0;
    endfunction

    function automatic int unsigned first_set_segment(input int unsigned from);
        for (int unsigned s = from; s < SEG_LIMIT; s++)
        begin
            if (bitmap[BW - 1 - s])
            begin
                return s;
            end
        end
        return SEG_LIMIT;
    endfunction

    // Advance to the next row; true when that wraps the frame.
    function automatic logic close_row();
        bitmap_count = 0;
        bitmap       = '0;
        seg          = 0;
        seg_byte     = 0;
        row++;
        if (row >= FRAME_HEIGHT)
        begin
            row = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [bsdf_pkg::BYTE_W-1:0] value, input logic restart_req);
        bsdf_pkg::result_t w;
        int unsigned       lin;
        w = '0;
        if (restart_req)
        begin
            restart_decoder();
        end
        if (raw_mode)
        begin
            w.pixel_address = raw_pos[AW-1:0];
            w.pixel_value   = value;
            w.write_enable  = 1'b1;
            raw_pos++;
            if (raw_pos >= RAW_PIXELS)
            begin
                raw_pos      = 0;
                raw_mode     = 1'b0;
                w.frame_done = 1'b1;
            end
            expected_writes.push_back(w);
        end
        else if (bitmap_count < 4)
        begin
            bitmap = {bitmap[BW-9:0], value};
            bitmap_count++;
            if (bitmap_count == 4)
            begin
                seg      = first_set_segment(0);
                seg_byte = 0;
                if (seg >= SEG_LIMIT)
                begin
                    // empty row: only the last one of the frame yields a marker
                    if (close_row())
                    begin
                        w.frame_done = 1'b1;
                        expected_writes.push_back(w);
                    end
                end
            end
        end
        else
        begin
            lin             = row * FRAME_WIDTH + seg * SEGMENT_BYTES + seg_byte;
            w.pixel_address = lin[AW-1:0];
            w.pixel_value   = value;
            w.write_enable  = 1'b1;
            seg_byte++;
            if (seg_byte >= SEGMENT_BYTES)
            begin
                seg_byte = 0;
                seg      = first_set_segment(seg + 1);
                if (seg >= SEG_LIMIT)
                begin
                    w.frame_done = close_row();
                end
            end
            expected_writes.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] pixel write mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_decoder();
            expected_writes.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    report_mismatch($sformatf("result at address %0d with no request waiting",
                                              pixel_address));
                end
                else
                begin
                    oldest = expected_writes.pop_front();
                    if (pixel_address !== oldest.pixel_address)
                    begin
                        report_mismatch($sformatf("pixel_address %0d, expected %0d",
                                                  pixel_address, oldest.pixel_address));
                    end
                    if (pixel_value !== oldest.pixel_value)
                    begin
                        report_mismatch($sformatf("pixel_value %0h at %0d, expected %0h",
                                                  pixel_value, oldest.pixel_address,
                                                  oldest.pixel_value));
                    end
                    if (write_enable !== oldest.write_enable)
                    begin
                        report_mismatch($sformatf("write_enable %b at %0d, expected %b",
                                                  write_enable, oldest.pixel_address,
                                                  oldest.write_enable));
                    end
                    if (frame_done !== oldest.frame_done)
                    begin
                        report_mismatch($sformatf("frame_done %b at %0d, expected %b",
                                                  frame_done, oldest.pixel_address,
                                                  oldest.frame_done));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_byte(byte_in, restart);
            end
            pending = expected_writes.size();
        end
    end

endmodule

/* bench/bitmap_segment_delta_frame_decoder_unit_test.sv */
`timescale 1ns / 1ps
// Top of the frame decoder test: drives the payload byte stream and the result ready,
// places the decoder beside its checker and prints the verdict.
// Depends on bsdf_pkg, bitmap_segment_delta_frame_decoder_unit and the checker module.
module bitmap_segment_delta_frame_decoder_unit_test;

    localparam int FRAME_WIDTH      = 320;
    localparam int FRAME_HEIGHT     = 180;
    localparam int SEGMENT_BYTES    = 10;
    localparam int SEGMENTS_PER_ROW = 32;
    localparam int SEG_LIMIT        = (SEGMENTS_PER_ROW > 32) ? 32 : SEGMENTS_PER_ROW;
    localparam int RAW_PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [bsdf_pkg::BYTE_W-1:0] byte_in;
    logic                        restart;
    logic                        out_valid;
    logic                        out_ready;
    logic [bsdf_pkg::ADDR_W-1:0] pixel_address;
    logic [bsdf_pkg::BYTE_W-1:0] pixel_value;
    logic                        write_enable;
    logic                        frame_done;
    int                          mismatches;
    int                          pending;
    logic                        stall_enable;
    int                          sent_count;

    bitmap_segment_delta_frame_decoder_unit #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .FRAME_HEIGHT    (FRAME_HEIGHT),
        .SEGMENT_BYTES   (SEGMENT_BYTES),
        .SEGMENTS_PER_ROW(SEGMENTS_PER_ROW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_address(pixel_address),
        .pixel_value  (pixel_value),
        .write_enable (write_enable),
        .frame_done   (frame_done)
    );

    bitmap_segment_delta_frame_decoder_checker #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .FRAME_HEIGHT    (FRAME_HEIGHT),
        .SEGMENT_BYTES   (SEGMENT_BYTES),
        .SEGMENTS_PER_ROW(SEGMENTS_PER_ROW)
    ) write_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_address(pixel_address),
        .pixel_value  (pixel_value),
        .write_enable (write_enable),
        .frame_done   (frame_done),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [bsdf_pkg::BYTE_W-1:0] value, input logic restart_req);
        if (stall_enable && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= value;
        restart  <= restart_req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_count++;
    endtask

    // Bitmap most significant byte first, then one run of bytes per set segment bit.
    task automatic send_row(input logic [31:0] bitmap);
        for (int i = 3; i >= 0; i--)
        begin
            send_byte(bitmap[8*i +: 8], 1'b0);
        end
        for (int s = 0; s < SEG_LIMIT; s++)
        begin
            if (bitmap[31 - s])
            begin
                repeat (SEGMENT_BYTES) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_enable && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned empty_pct;
        int unsigned pick;
        int          random_start;
        logic [31:0] bitmap;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        byte_in      = '0;
        restart      = 1'b0;
        stall_enable = 1'b1;
        sent_count   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        // restart inside the raw frame: writes start over at address 0
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);

        // full raw frame opened by a restart; everything after it is delta coded
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (RAW_PIXELS - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);

        // segments at both row ends, a full row, then empty rows ending in a marker
        for (int r = 0; r < FRAME_HEIGHT; r++)
        begin
            send_row(r == 0 ? 32'h8000_0001 : (r == 1 ? 32'hFFFF_FFFF : 32'h0));
        end
        // only the last segment of the last row: top address closes the frame
        for (int r = 0; r < FRAME_HEIGHT; r++)
        begin
            send_row(r == FRAME_HEIGHT - 1 ? 32'h0000_0001 : 32'h0);
        end

        random_start = sent_count;
        while (sent_count - random_start < 1700)
        begin
            empty_pct = $urandom_range(80, 98);
            for (int r = 0; r < FRAME_HEIGHT; r++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < empty_pct)
                    bitmap = '0;
                else if (pick < 97)
                    bitmap = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
                else if (pick < 99)
                    bitmap = $urandom();
                else
                    bitmap = '1;
                send_row(bitmap);
            end
        end

        // leave a segment half written, feed noise, then restart from wherever it stands
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (60) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (RAW_PIXELS - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);

        stall_enable = 1'b0;
        // drop back to raw halfway through a row bitmap
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
        in_valid <= 1'b0;
        restart  <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("timeout: decoder stopped taking requests or returning results");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
